// File: src/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and constants for the resizing stack engine: request and
// result item layouts, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package rse_pkg;

  // Default number of stack entries
  localparam int unsigned RseDepth = 1024;

  // Field widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 11;
  localparam int unsigned CapW   = 12;
  localparam int unsigned StartW = 11;

  // Start capacity after reset
  localparam logic [StartW-1:0] StartCapRst = StartW'(10);

  // Capacity saturation point
  localparam logic [CapW-1:0] CapMax = '1;

  // Request codes
  localparam logic ReqPush = 1'b0;
  localparam logic ReqPop  = 1'b1;

  // Request item
  typedef struct packed {
    logic                    req_type;
    logic signed [DataW-1:0] push_value;
  } rse_in_t;

  // Result item
  typedef struct packed {
    logic signed [DataW-1:0] pop_value;
    logic                    empty_error;
    logic                    overflow;
    logic [CountW-1:0]       item_count;
    logic [CapW-1:0]         capacity_now;
    logic [CapW-1:0]         peak_capacity;
  } rse_out_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } rse_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // take the request and update the stack state
    logic load_rd;  // capture memory read data as the popped value
  } rse_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_pending;  // current request is a pop of a non-empty stack
  } rse_status_t;

endpackage

// File: src/rse_ctrl.sv
// ----------------------------------------------------------------------------
// rse_ctrl
// Controller state machine: accepts one request, waits for the memory read
// on a non-empty pop, then holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module rse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rse_pkg::rse_status_t status_i,
  output rse_pkg::rse_cmd_t    cmd_o
);
  import rse_pkg::*;

  rse_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.rd_pending ? ST_READ : ST_RESP;
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.accept  = 1'b0;
    cmd_o.load_rd = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_READ: begin
        cmd_o.load_rd = 1'b1;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: src/rse_dp.sv
// ----------------------------------------------------------------------------
// rse_dp
// Datapath: stack memory, item count, capacity statistics and the result
// register.
// ----------------------------------------------------------------------------
module rse_dp #(
  parameter int unsigned DEPTH = rse_pkg::RseDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rse_pkg::StartW-1:0]        cfg_wdata_i,
  input  rse_pkg::rse_in_t                  in_data_i,
  input  rse_pkg::rse_cmd_t                 cmd_i,
  output rse_pkg::rse_status_t              status_o,
  output rse_pkg::rse_out_t                 out_data_o
);
  import rse_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > CapW) ? CntW : CapW;

  logic [DataW-1:0]  mem_q [DEPTH];
  logic [DataW-1:0]  rd_data_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CapW-1:0]   cap_q, cap_d;
  logic [CapW-1:0]   peak_q, peak_d;
  logic [CapW-1:0]   start_eff;
  logic [CapW-1:0]   cap_dbl;
  logic [CapW-1:0]   cap_half;
  logic [CntW-1:0]   top_idx;
  logic              is_pop, is_empty, is_full;
  logic              do_push, do_pop;
  rse_out_t          res_q, res_d;

  // Request decode
  assign is_pop   = (in_data_i.req_type == ReqPop);
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(DEPTH));
  assign do_push  = cmd_i.accept && !is_pop && !is_full;
  assign do_pop   = cmd_i.accept && is_pop && !is_empty;
  assign top_idx  = count_q - CntW'(1);

  assign status_o.rd_pending = is_pop && !is_empty;

  // Start capacity of zero counts as one
  assign start_eff = (cfg_wdata_i == '0) ? CapW'(1) : CapW'(cfg_wdata_i);

  // Doubling saturates, halving floors at one
  assign cap_dbl  = cap_q[CapW-1] ? CapMax : {cap_q[CapW-2:0], 1'b0};
  assign cap_half = cap_q >> 1;

  // Next count, capacity and peak
  always_comb begin
    count_d = count_q;
    cap_d   = cap_q;
    peak_d  = peak_q;
    if (do_push) begin
      count_d = count_q + CntW'(1);
      if (CmpW'(count_q) == CmpW'(cap_q)) begin
        cap_d = cap_dbl;
        if (cap_dbl > peak_q) begin
          peak_d = cap_dbl;
        end
      end
    end else if (do_pop) begin
      count_d = top_idx;
      if (CmpW'(count_q) < CmpW'(cap_half)) begin
        cap_d = (cap_half == '0) ? CapW'(1) : cap_half;
      end
    end
  end

  // Stack state; a config write restarts the stack
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CapW'(StartCapRst);
      peak_q  <= CapW'(StartCapRst);
    end else if (cfg_we_i) begin
      count_q <= '0;
      cap_q   <= start_eff;
      peak_q  <= start_eff;
    end else begin
      count_q <= count_d;
      cap_q   <= cap_d;
      peak_q  <= peak_d;
    end
  end

  // Stack memory: write on push, registered read of the top on pop
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[count_q[AddrW-1:0]] <= in_data_i.push_value;
    end
    if (do_pop) begin
      rd_data_q <= mem_q[top_idx[AddrW-1:0]];
    end
  end

  // Result fields
  always_comb begin
    res_d               = res_q;
    res_d.empty_error   = is_pop && is_empty;
    res_d.overflow      = !is_pop && is_full;
    res_d.pop_value     = (is_pop && is_empty) ? '1 : '0;
    res_d.item_count    = CountW'(count_d);
    res_d.capacity_now  = cap_d;
    res_d.peak_capacity = peak_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_q <= res_d;
    end else if (cmd_i.load_rd) begin
      res_q.pop_value <= rd_data_q;
    end
  end

  assign out_data_o = res_q;

endmodule

// File: src/resizing_stack_engine.sv
// Timing: a push or an empty pop shows its result the cycle after acceptance,
// a non-empty pop only after a further READ state (registered stack memory read).
// Flow: one item at a time; the next item is accepted the cycle after
// the result is taken.
// Reset: count 0, capacity and peak 10, start capacity 10; memory not cleared.
// ----------------------------------------------------------------------------
// resizing_stack_engine
// Stack of signed 32-bit values with a doubling/halving capacity statistic
// and its peak, built as a controller plus datapath.
// ----------------------------------------------------------------------------
module resizing_stack_engine #(
  parameter int unsigned DEPTH = rse_pkg::RseDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rse_pkg::StartW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rse_pkg::rse_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rse_pkg::rse_out_t          out_data_o
);
  import rse_pkg::*;

  rse_cmd_t    cmd;
  rse_status_t status;

  // Sequencing
  rse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic
  rse_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

// File: src/rse_checker.sv
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks for the resizing stack engine, bound to the top level.
// ----------------------------------------------------------------------------
module rse_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input rse_pkg::rse_out_t          out_data_o
);
  import rse_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // One item in flight: no acceptance while a result waits
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("item accepted while result pending");

  // Empty pop reports -1 on an empty stack, never together with overflow
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_error |->
      out_data_o.pop_value == '1 && out_data_o.item_count == '0 &&
      !out_data_o.overflow)
    else $error("bad empty pop result");

  // Capacity never exceeds its peak
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.capacity_now <= out_data_o.peak_capacity)
    else $error("capacity above peak");

endmodule

bind resizing_stack_engine rse_checker u_rse_checker (.*);
